>>> hdl/cbor_retry_after_scanner_assert.svh
// ----------------------------------------------------------------------------
// cbor_retry_after_scanner_assert.svh
// Assertion macros for the backoff key scanner.
// ----------------------------------------------------------------------------
`ifndef CBOR_RETRY_AFTER_SCANNER_ASSERT_SVH
`define CBOR_RETRY_AFTER_SCANNER_ASSERT_SVH

// same-cycle implication
`define CRAS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CRAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/cras_pkg.sv
// ----------------------------------------------------------------------------
// cras_pkg
// Types, codes and constants for the backoff key scanner.
// ----------------------------------------------------------------------------
package cras_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_payload;
    } req_t;

    typedef struct packed {
        logic [15:0] duration_s;
        logic        found_flag;
    } rsp_t;

    typedef enum logic [3:0] {
        PH_HDR  = 4'd0,
        PH_CNT  = 4'd1,
        PH_KEY  = 4'd2,
        PH_KEYB = 4'd3,
        PH_VAL  = 4'd4,
        PH_U8   = 4'd5,
        PH_U16H = 4'd6,
        PH_U16L = 4'd7,
        PH_SKIP = 4'd8,
        PH_DONE = 4'd9
    } phase_t;

    localparam logic [7:0]  CFG_DEFAULT_IDX = 8'd0;
    localparam logic [7:0]  CFG_MAX_IDX     = 8'd1;
    localparam logic [15:0] DEFAULT_RESET   = 16'd60;
    localparam logic [15:0] MAX_RESET       = 16'd3600;

    localparam logic [2:0] MAJ_UINT  = 3'd0;
    localparam logic [2:0] MAJ_BYTES = 3'd2;
    localparam logic [2:0] MAJ_TEXT  = 3'd3;
    localparam logic [2:0] MAJ_MAP   = 3'd5;

    localparam logic [4:0] INFO_1B = 5'd24;
    localparam logic [4:0] INFO_2B = 5'd25;

    localparam logic [4:0] KEY_LEN = 5'd11;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h72;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h74;
            4'd3:    c = 8'h72;
            4'd4:    c = 8'h79;
            4'd5:    c = 8'h5F;
            4'd6:    c = 8'h61;
            4'd7:    c = 8'h66;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/cbor_retry_after_scanner.sv
// ----------------------------------------------------------------------------
// cbor_retry_after_scanner
// Byte-serial CBOR map scanner returning the clamped backoff value, or the default when the key is absent.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall/req) carries one payload byte per
// request, with last_byte marking the final byte and empty_payload ending the
// payload without a byte. Each request enters an input register and is parsed
// the next cycle by the map parser; an ending request loads the result register
// when no stalled response holds it. rsp_valid/rsp_stall/rsp carry one response
// per payload. Throughput is one request per cycle while the input register is
// not stalled, set by the single parse stage between the registers.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is default_backoff_s, index 1 is the backoff cap, others drop.
// Reset clears the parser, empties both registers and loads the reset values
// of the two config registers. A stalled response holds in the result
// register; the parse stage keeps taking bytes that produce no response, and
// req_stall rises only when an ending request meets a full, stalled result.
// ----------------------------------------------------------------------------
module cbor_retry_after_scanner
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cras_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cras_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    `include "cbor_retry_after_scanner_assert.svh"

    logic [15:0]      default_reg;
    logic [15:0]      max_reg;

    logic             s1_valid_reg;
    cras_pkg::req_t   s1_req_reg;

    logic             rsp_valid_reg;
    cras_pkg::rsp_t   rsp_reg;

    cras_pkg::phase_t phase_reg,     phase_next;
    logic [7:0]       pairs_reg,     pairs_next;
    logic [4:0]       kbl_reg,       kbl_next;
    logic [3:0]       kidx_reg,      kidx_next;
    logic             kmatch_reg,    kmatch_next;
    logic [4:0]       skip_reg,      skip_next;
    logic [15:0]      accum_reg,     accum_next;
    logic             decided_reg,   decided_next;
    logic [15:0]      held_dur_reg,  held_dur_next;
    logic             held_fnd_reg,  held_fnd_next;

    logic             s1_emit;
    logic             s1_go;
    logic             s1_fire;
    cras_pkg::rsp_t   rsp_next;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign s1_emit   = s1_valid_reg && (s1_req_reg.empty_payload || s1_req_reg.last_byte);
    assign s1_go     = !(s1_emit && rsp_valid_reg && rsp_stall);
    assign s1_fire   = s1_valid_reg && s1_go;
    assign req_stall = s1_valid_reg && !s1_go;

    always_comb
    begin
        logic [7:0]  b;
        logic [2:0]  major;
        logic [4:0]  info;
        logic        dec;
        logic        dec_found;
        logic [15:0] dec_val;
        logic        cnt_set;
        logic [7:0]  cnt_val;
        logic        fin;
        logic [15:0] fin_val;
        logic        endp;

        b         = s1_req_reg.data_byte;
        major     = b[7:5];
        info      = b[4:0];
        dec       = 1'b0;
        dec_found = 1'b0;
        dec_val   = '0;
        cnt_set   = 1'b0;
        cnt_val   = '0;
        fin       = 1'b0;
        fin_val   = '0;
        endp      = 1'b0;

        phase_next    = phase_reg;
        pairs_next    = pairs_reg;
        kbl_next      = kbl_reg;
        kidx_next     = kidx_reg;
        kmatch_next   = kmatch_reg;
        skip_next     = skip_reg;
        accum_next    = accum_reg;
        decided_next  = decided_reg;
        held_dur_next = held_dur_reg;
        held_fnd_next = held_fnd_reg;

        if (!s1_req_reg.empty_payload)
        begin
            case (phase_reg)
                cras_pkg::PH_HDR:
                begin
                    if (major != cras_pkg::MAJ_MAP)
                        dec = 1'b1;
                    else if (info == cras_pkg::INFO_1B)
                        phase_next = cras_pkg::PH_CNT;
                    else
                    begin
                        cnt_set = 1'b1;
                        cnt_val = {3'b000, info};
                    end
                end
                cras_pkg::PH_CNT:
                begin
                    cnt_set = 1'b1;
                    cnt_val = b;
                end
                cras_pkg::PH_KEY:
                begin
                    if (major != cras_pkg::MAJ_TEXT || info >= cras_pkg::INFO_1B)
                        dec = 1'b1;
                    else
                    begin
                        kmatch_next = (info == cras_pkg::KEY_LEN);
                        kidx_next   = '0;
                        kbl_next    = info;
                        phase_next  = (info == 5'd0) ? cras_pkg::PH_VAL : cras_pkg::PH_KEYB;
                    end
                end
                cras_pkg::PH_KEYB:
                begin
                    if ({1'b0, kidx_reg} < cras_pkg::KEY_LEN)
                    begin
                        if (b != cras_pkg::key_char(kidx_reg))
                            kmatch_next = 1'b0;
                        kidx_next = kidx_reg + 4'd1;
                    end
                    else
                        kmatch_next = 1'b0;
                    kbl_next = kbl_reg - 5'd1;
                    if (kbl_reg == 5'd1)
                        phase_next = cras_pkg::PH_VAL;
                end
                cras_pkg::PH_VAL:
                begin
                    if (major == cras_pkg::MAJ_UINT)
                    begin
                        if (info < cras_pkg::INFO_1B)
                        begin
                            fin     = 1'b1;
                            fin_val = {11'd0, info};
                        end
                        else if (info == cras_pkg::INFO_1B)
                            phase_next = cras_pkg::PH_U8;
                        else if (info == cras_pkg::INFO_2B)
                            phase_next = cras_pkg::PH_U16H;
                        else
                            dec = 1'b1;
                    end
                    else if (major == cras_pkg::MAJ_BYTES || major == cras_pkg::MAJ_TEXT)
                    begin
                        if (info >= cras_pkg::INFO_1B)
                            dec = 1'b1;
                        else if (info == 5'd0)
                            endp = 1'b1;
                        else
                        begin
                            skip_next  = info;
                            phase_next = cras_pkg::PH_SKIP;
                        end
                    end
                    else
                        dec = 1'b1;
                end
                cras_pkg::PH_U8:
                begin
                    fin     = 1'b1;
                    fin_val = {8'd0, b};
                end
                cras_pkg::PH_U16H:
                begin
                    accum_next = {b, 8'd0};
                    phase_next = cras_pkg::PH_U16L;
                end
                cras_pkg::PH_U16L:
                begin
                    accum_next = accum_reg | {8'd0, b};
                    fin        = 1'b1;
                    fin_val    = accum_reg | {8'd0, b};
                end
                cras_pkg::PH_SKIP:
                begin
                    skip_next = skip_reg - 5'd1;
                    if (skip_reg == 5'd1)
                        endp = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (cnt_set)
        begin
            pairs_next = cnt_val;
            if (cnt_val == 8'd0)
                dec = 1'b1;
            else
                phase_next = cras_pkg::PH_KEY;
        end

        if (fin)
        begin
            if (kmatch_reg)
            begin
                dec       = 1'b1;
                dec_found = 1'b1;
                dec_val   = fin_val;
            end
            else
                endp = 1'b1;
        end

        if (endp)
        begin
            pairs_next = pairs_reg - 8'd1;
            if (pairs_reg == 8'd1)
                dec = 1'b1;
            else
                phase_next = cras_pkg::PH_KEY;
        end

        if (dec)
        begin
            decided_next  = 1'b1;
            held_fnd_next = dec_found;
            held_dur_next = !dec_found ? 16'd0 : ((dec_val > max_reg) ? max_reg : dec_val);
            phase_next    = cras_pkg::PH_DONE;
        end

        if (decided_next && held_fnd_next)
        begin
            rsp_next.duration_s = held_dur_next;
            rsp_next.found_flag = 1'b1;
        end
        else
        begin
            rsp_next.duration_s = default_reg;
            rsp_next.found_flag = 1'b0;
        end

        if (s1_emit)
        begin
            phase_next    = cras_pkg::PH_HDR;
            pairs_next    = '0;
            kbl_next      = '0;
            kidx_next     = '0;
            kmatch_next   = 1'b0;
            skip_next     = '0;
            accum_next    = '0;
            decided_next  = 1'b0;
            held_dur_next = '0;
            held_fnd_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= cras_pkg::DEFAULT_RESET;
            max_reg     <= cras_pkg::MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == cras_pkg::CFG_DEFAULT_IDX)
                default_reg <= cfg_data;
            else if (cfg_index == cras_pkg::CFG_MAX_IDX)
                max_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!req_stall)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            s1_req_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= cras_pkg::PH_HDR;
            pairs_reg    <= '0;
            kbl_reg      <= '0;
            kidx_reg     <= '0;
            kmatch_reg   <= 1'b0;
            skip_reg     <= '0;
            accum_reg    <= '0;
            decided_reg  <= 1'b0;
            held_dur_reg <= '0;
            held_fnd_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            phase_reg    <= phase_next;
            pairs_reg    <= pairs_next;
            kbl_reg      <= kbl_next;
            kidx_reg     <= kidx_next;
            kmatch_reg   <= kmatch_next;
            skip_reg     <= skip_next;
            accum_reg    <= accum_next;
            decided_reg  <= decided_next;
            held_dur_reg <= held_dur_next;
            held_fnd_reg <= held_fnd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (s1_fire && s1_emit)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit)
            rsp_reg <= rsp_next;
    end

    `CRAS_ASSERT_SAME(a_found_capped, rsp_valid_reg && rsp_reg.found_flag, rsp_reg.duration_s <= max_reg)
    `CRAS_ASSERT_NEXT(a_emit_clears, s1_fire && s1_emit, phase_reg == cras_pkg::PH_HDR && !decided_reg)
    `CRAS_ASSERT_SAME(a_done_decided, 1'b1, decided_reg == (phase_reg == cras_pkg::PH_DONE))
    `CRAS_ASSERT_SAME(a_stall_cause, req_stall, s1_emit && rsp_valid_reg && rsp_stall)

endmodule

>>> sim/cbor_retry_after_scanner_tb.sv
// ----------------------------------------------------------------------------
// cbor_retry_after_scanner_tb
// Self-checking bench for the byte-serial backoff key scanner.
// ----------------------------------------------------------------------------
// Feeds CBOR payloads one byte per request: a short directed set, then random
// maps with the wanted key, near misses, broken headers, truncation and noise,
// across several backoff settings. A scoreboard class tracks parse state,
// predicts one response per payload and compares it with the block's output.
// The sender works in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module cbor_retry_after_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEMS_PER_PHASE = 300;
    localparam int          CYCLE_LIMIT     = 600000;
    localparam logic [87:0] KEY_WORD        = 88'h72_65_74_72_79_5F_61_66_74_65_72;

    typedef logic [7:0] octet_q_t[$];

    class backoff_scoreboard;
        logic [15:0]      dflt_s;
        logic [15:0]      cap_s;
        cras_pkg::phase_t phase;
        logic [7:0]       pairs_left;
        logic [4:0]       key_left;
        logic [3:0]       key_idx;
        logic             key_hit;
        logic [4:0]       skip_left;
        logic [15:0]      accum;
        logic             decided;
        logic [15:0]      held_s;
        logic             held_found;
        cras_pkg::rsp_t   expected_q[$];
        int               errors;

        function new();
            dflt_s = cras_pkg::DEFAULT_RESET;
            cap_s  = cras_pkg::MAX_RESET;
            errors = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase      = cras_pkg::PH_HDR;
            pairs_left = 8'd0;
            key_left   = 5'd0;
            key_idx    = 4'd0;
            key_hit    = 1'b0;
            skip_left  = 5'd0;
            accum      = 16'd0;
            decided    = 1'b0;
            held_s     = 16'd0;
            held_found = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic [7:0] idx, logic [15:0] val);
            if (idx == cras_pkg::CFG_DEFAULT_IDX)
                dflt_s = val;
            else if (idx == cras_pkg::CFG_MAX_IDX)
                cap_s = val;
        endfunction

        function void decide(logic found, logic [15:0] val);
            decided    = 1'b1;
            held_found = found;
            held_s     = !found ? 16'd0 : ((val > cap_s) ? cap_s : val);
            phase      = cras_pkg::PH_DONE;
        endfunction

        function void end_pair();
            pairs_left = pairs_left - 8'd1;
            if (pairs_left == 8'd0)
                decide(1'b0, 16'd0);
            else
                phase = cras_pkg::PH_KEY;
        endfunction

        function void finish_uint(logic [15:0] val);
            if (key_hit)
                decide(1'b1, val);
            else
                end_pair();
        endfunction

        function void set_count(logic [7:0] n);
            pairs_left = n;
            if (n == 8'd0)
                decide(1'b0, 16'd0);
            else
                phase = cras_pkg::PH_KEY;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [2:0] major;
            logic [4:0] info;
            major = b[7:5];
            info  = b[4:0];
            case (phase)
                cras_pkg::PH_HDR:
                begin
                    if (major != cras_pkg::MAJ_MAP)
                        decide(1'b0, 16'd0);
                    else if (info == cras_pkg::INFO_1B)
                        phase = cras_pkg::PH_CNT;
                    else
                        set_count({3'd0, info});
                end
                cras_pkg::PH_CNT:
                    set_count(b);
                cras_pkg::PH_KEY:
                begin
                    if (major != cras_pkg::MAJ_TEXT || info >= cras_pkg::INFO_1B)
                    begin
                        decide(1'b0, 16'd0);
                    end
                    else
                    begin
                        key_hit  = (info == cras_pkg::KEY_LEN);
                        key_idx  = 4'd0;
                        key_left = info;
                        phase    = (info == 5'd0) ? cras_pkg::PH_VAL : cras_pkg::PH_KEYB;
                    end
                end
                cras_pkg::PH_KEYB:
                begin
                    if ({1'b0, key_idx} < cras_pkg::KEY_LEN)
                    begin
                        if (b != KEY_WORD[8 * (10 - key_idx) +: 8])
                            key_hit = 1'b0;
                        key_idx = key_idx + 4'd1;
                    end
                    else
                    begin
                        key_hit = 1'b0;
                    end
                    key_left = key_left - 5'd1;
                    if (key_left == 5'd0)
                        phase = cras_pkg::PH_VAL;
                end
                cras_pkg::PH_VAL:
                begin
                    if (major == cras_pkg::MAJ_UINT)
                    begin
                        if (info < cras_pkg::INFO_1B)
                            finish_uint({11'd0, info});
                        else if (info == cras_pkg::INFO_1B)
                            phase = cras_pkg::PH_U8;
                        else if (info == cras_pkg::INFO_2B)
                            phase = cras_pkg::PH_U16H;
                        else
                            decide(1'b0, 16'd0);
                    end
                    else if (major == cras_pkg::MAJ_BYTES || major == cras_pkg::MAJ_TEXT)
                    begin
                        if (info >= cras_pkg::INFO_1B)
                            decide(1'b0, 16'd0);
                        else if (info == 5'd0)
                            end_pair();
                        else
                        begin
                            skip_left = info;
                            phase     = cras_pkg::PH_SKIP;
                        end
                    end
                    else
                    begin
                        decide(1'b0, 16'd0);
                    end
                end
                cras_pkg::PH_U8:
                    finish_uint({8'd0, b});
                cras_pkg::PH_U16H:
                begin
                    accum = {b, 8'd0};
                    phase = cras_pkg::PH_U16L;
                end
                cras_pkg::PH_U16L:
                begin
                    accum = accum | {8'd0, b};
                    finish_uint(accum);
                end
                cras_pkg::PH_SKIP:
                begin
                    skip_left = skip_left - 5'd1;
                    if (skip_left == 5'd0)
                        end_pair();
                end
                default:
                    ;
            endcase
        endfunction

        function void note_req(cras_pkg::req_t r);
            cras_pkg::rsp_t e;
            if (!r.empty_payload)
                take_byte(r.data_byte);
            if (r.empty_payload || r.last_byte)
            begin
                e.found_flag = decided && held_found;
                e.duration_s = e.found_flag ? held_s : dflt_s;
                expected_q.push_back(e);
                clear_parse();
            end
        endfunction

        function void check_rsp(cras_pkg::rsp_t r);
            cras_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response: duration_s %0d found_flag %0d",
                       r.duration_s, r.found_flag);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r.duration_s !== e.duration_s)
            begin
                $error("duration_s mismatch: expected %0d, actual %0d",
                       e.duration_s, r.duration_s);
                errors++;
            end
            if (r.found_flag !== e.found_flag)
            begin
                $error("found_flag mismatch: expected %0d, actual %0d",
                       e.found_flag, r.found_flag);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    cras_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    cras_pkg::rsp_t rsp;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [7:0]     cfg_index;
    logic [15:0]    cfg_data;

    backoff_scoreboard sb;
    int cycles     = 0;
    int burst_left = 0;
    int items_sent = 0;
    int stall_mode = 0;
    int stall_run  = 0;

    cbor_retry_after_scanner i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_rsp(rsp);
    end

    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(4, 60);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            2:       rsp_stall <= (stall_run % 5) != 0;
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send(cras_pkg::req_t r);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        sb.note_req(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_payload(octet_q_t q, bit end_empty);
        cras_pkg::req_t r;
        foreach (q[i])
        begin
            r.data_byte     = q[i];
            r.last_byte     = (i == q.size() - 1) && !end_empty;
            r.empty_payload = 1'b0;
            send(r);
        end
        if (end_empty)
        begin
            r.data_byte     = 8'($urandom);
            r.last_byte     = 1'($urandom);
            r.empty_payload = 1'b1;
            send(r);
        end
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic void add_key(ref octet_q_t q);
        int n;
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
        begin
            q.push_back({cras_pkg::MAJ_TEXT, cras_pkg::KEY_LEN});
            for (int i = 0; i < 11; i++)
                q.push_back(KEY_WORD[8 * (10 - i) +: 8]);
            if (k == 4)
                q[q.size() - 1 - $urandom_range(0, 10)] = 8'($urandom);
        end
        else if (k == 9 && $urandom_range(0, 3) == 0)
        begin
            q.push_back(8'($urandom));
        end
        else
        begin
            n = (k == 9) ? $urandom_range(0, 23) : $urandom_range(0, 14);
            q.push_back({cras_pkg::MAJ_TEXT, 5'(n)});
            repeat (n) q.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_value(ref octet_q_t q);
        logic [15:0] v;
        int          n;
        case ($urandom_range(0, 9))
            0, 1:
                q.push_back({cras_pkg::MAJ_UINT, 5'($urandom_range(0, 23))});
            2, 3:
            begin
                q.push_back({cras_pkg::MAJ_UINT, cras_pkg::INFO_1B});
                q.push_back(8'($urandom));
            end
            4, 5, 6:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'hFFFF;
                    1:       v = sb.cap_s;
                    2:       v = sb.cap_s + 16'd1;
                    3:       v = sb.cap_s - 16'd1;
                    default: v = 16'($urandom);
                endcase
                q.push_back({cras_pkg::MAJ_UINT, cras_pkg::INFO_2B});
                q.push_back(v[15:8]);
                q.push_back(v[7:0]);
            end
            7, 8:
            begin
                n = ($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 6);
                q.push_back({($urandom_range(0, 1) == 1) ? cras_pkg::MAJ_TEXT
                                                         : cras_pkg::MAJ_BYTES,
                             5'(n)});
                repeat (n) q.push_back(8'($urandom));
            end
            default:
                q.push_back(8'($urandom));
        endcase
    endfunction

    task automatic random_payload();
        octet_q_t q;
        int       pairs;
        int       count;
        int       kind;
        int       cut;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
        end
        else
        begin
            pairs = $urandom_range(0, 5);
            count = pairs;
            if (kind == 1)
                count = pairs + $urandom_range(1, 3);
            else if (kind == 2 && pairs > 0)
                count = $urandom_range(0, pairs - 1);
            if (kind == 3)
            begin
                q.push_back({cras_pkg::MAJ_MAP, 5'($urandom_range(25, 31))});
            end
            else if (kind == 4)
            begin
                q.push_back({cras_pkg::MAJ_MAP, cras_pkg::INFO_1B});
                q.push_back(8'($urandom));
            end
            else if (kind == 5)
            begin
                q.push_back({cras_pkg::MAJ_MAP, cras_pkg::INFO_1B});
                q.push_back(8'(count));
            end
            else
            begin
                q.push_back({cras_pkg::MAJ_MAP, 5'(count)});
            end
            repeat (pairs)
            begin
                add_key(q);
                add_value(q);
            end
            if (kind == 6)
                repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
            if (kind == 7 && q.size() > 1)
                q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            if (kind == 8 && q.size() > 1)
            begin
                cut = $urandom_range(1, q.size() - 1);
                while (q.size() > cut) void'(q.pop_back());
            end
        end
        send_payload(q, $urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        octet_q_t q;
        int       target;
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = 8'd0;
        cfg_data  = 16'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_payload(q, 1'b1);
        q.push_back(8'hFF);
        send_payload(q, 1'b0);
        q.delete();
        q.push_back({cras_pkg::MAJ_MAP, 5'd0});
        send_payload(q, 1'b0);
        q.delete();
        q.push_back({cras_pkg::MAJ_MAP, cras_pkg::INFO_1B});
        q.push_back(8'h00);
        send_payload(q, 1'b0);
        q.delete();
        q.push_back({cras_pkg::MAJ_MAP, 5'd1});
        q.push_back({cras_pkg::MAJ_TEXT, cras_pkg::KEY_LEN});
        for (int i = 0; i < 11; i++)
            q.push_back(KEY_WORD[8 * (10 - i) +: 8]);
        q.push_back({cras_pkg::MAJ_UINT, cras_pkg::INFO_2B});
        q.push_back(8'hFF);
        q.push_back(8'hFF);
        send_payload(q, 1'b0);
        q.delete();
        q.push_back({cras_pkg::MAJ_MAP, 5'd1});
        send_payload(q, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_reg(cras_pkg::CFG_DEFAULT_IDX, 16'd0);
                    write_reg(cras_pkg::CFG_MAX_IDX, 16'd0);
                    write_reg(8'hFF, 16'hFFFF);
                end
                1:
                begin
                    write_reg(cras_pkg::CFG_DEFAULT_IDX, 16'hFFFF);
                    write_reg(cras_pkg::CFG_MAX_IDX, 16'hFFFF);
                end
                3:
                begin
                    write_reg(cras_pkg::CFG_DEFAULT_IDX, 16'd0);
                    write_reg(cras_pkg::CFG_MAX_IDX, 16'hFFFF);
                end
                4:
                begin
                    write_reg(cras_pkg::CFG_DEFAULT_IDX, 16'hFFFF);
                    write_reg(cras_pkg::CFG_MAX_IDX, 16'd0);
                end
                5:
                begin
                    write_reg(cras_pkg::CFG_DEFAULT_IDX, 16'($urandom));
                    write_reg(cras_pkg::CFG_MAX_IDX, 16'($urandom_range(0, 300)));
                end
                default:
                begin
                    write_reg(cras_pkg::CFG_DEFAULT_IDX, 16'($urandom));
                    write_reg(cras_pkg::CFG_MAX_IDX, 16'($urandom));
                end
            endcase
            write_reg(8'($urandom_range(2, 255)), 16'($urandom));
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) random_payload();
        end
        drain();

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
